[sv/iflf_pkg.sv]
// shared types and constants for the in-flight limited fifo
// no dependencies; imported by the cell, chain and top modules
package iflf_pkg;

  localparam int DEPTH     = 32;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = 6;

  localparam logic [CNT_W-1:0] DEPTH_COUNT     = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] LIMIT_RESET_VAL = CNT_W'(8);

  // request operation codes
  typedef enum logic [2:0] {
    OP_PUSH        = 3'd0,
    OP_TAKE        = 3'd1,
    OP_RETIRE      = 3'd2,
    OP_CLEAR_TAKEN = 3'd3,
    OP_CLEAR_ALL   = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_EMPTY     = 3'd2,
    STAT_LIMIT     = 3'd3,
    STAT_NOT_TAKEN = 3'd4
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR_TAKEN,
    S_CLEAR_ALL
  } state_t;

  // per-cell control
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // control of the whole chain
  typedef struct packed {
    logic             push;
    logic             shift;
    logic [IDX_W-1:0] push_idx;
    logic [IDX_W-1:0] take_idx;
  } chain_ctrl_t;

endpackage

[sv/iflf_cell.sv]
// one storage cell of the fifo chain: holds a word, loads on push,
// takes its neighbor's word on a shift; depends on iflf_pkg
module iflf_cell (
  input  logic                           clk,
  input  iflf_pkg::cell_ctrl_t           ctrl,
  input  logic [iflf_pkg::WORD_BITS-1:0] load_word,
  input  logic [iflf_pkg::WORD_BITS-1:0] next_word,
  output logic [iflf_pkg::WORD_BITS-1:0] word
);
  import iflf_pkg::*;

  // word register, no reset: only held entries are ever read
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      word <= next_word;
    end else if (ctrl.load) begin
      word <= load_word;
    end
  end

endmodule

[sv/iflf_chain.sv]
// row of DEPTH cells, oldest item in cell 0; a pop shifts every cell
// toward the head; depends on iflf_pkg and iflf_cell
module iflf_chain (
  input  logic                           clk,
  input  iflf_pkg::chain_ctrl_t          ctrl,
  input  logic [iflf_pkg::WORD_BITS-1:0] payload,
  output logic [iflf_pkg::WORD_BITS-1:0] head_word,
  output logic [iflf_pkg::WORD_BITS-1:0] take_word
);
  import iflf_pkg::*;

  logic [WORD_BITS-1:0] cell_word [DEPTH];
  logic [WORD_BITS-1:0] cell_next [DEPTH];
  cell_ctrl_t           cell_ctrl [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    // the cell at the fill position takes the pushed word
    assign cell_ctrl[i].load  = ctrl.push && (ctrl.push_idx == IDX_W'(i));
    assign cell_ctrl[i].shift = ctrl.shift;

    // neighbor toward the tail feeds this cell on a shift
    if (i == DEPTH - 1) begin : g_tail
      assign cell_next[i] = cell_word[i];
    end else begin : g_mid
      assign cell_next[i] = cell_word[i + 1];
    end

    iflf_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl[i]),
      .load_word (payload),
      .next_word (cell_next[i]),
      .word      (cell_word[i])
    );
  end

  // oldest item and the oldest item not yet taken
  assign head_word = cell_word[0];
  assign take_word = cell_word[ctrl.take_idx];

endmodule

[sv/in_flight_limited_fifo_top.sv]
// in-flight limited fifo: push, take, retire and clear requests over a cell chain
// push, take and retire: result registered in the cycle after the request, 1 request per
// cycle; clears: 1 result per cycle from the chain head, none when there is nothing to
// clear; requests are stalled meanwhile and whenever the result register is stalled
// reset is synchronous: counters cleared, limit set to 8, cell words left as they are
module in_flight_limited_fifo_top (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     op,
  input  logic [iflf_pkg::WORD_BITS-1:0] payload,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     status,
  output logic [iflf_pkg::WORD_BITS-1:0] item_word,
  output logic                           last,
  output logic [iflf_pkg::CNT_W-1:0]     entries,
  output logic [iflf_pkg::CNT_W-1:0]     taken_count,
  // limit register write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [iflf_pkg::CNT_W-1:0]     cfg_data
);
  import iflf_pkg::*;

  state_t               state, state_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [CNT_W-1:0]     in_flight, in_flight_next;
  logic [CNT_W-1:0]     max_in_flight;
  logic                 out_valid_next;
  logic                 emit;
  status_t              emit_status;
  logic [WORD_BITS-1:0] emit_word;
  logic                 emit_last;
  logic                 slot_free;
  logic                 accept;
  chain_ctrl_t          chain_ctrl;
  logic [WORD_BITS-1:0] head_word;
  logic [WORD_BITS-1:0] take_word;

  assign cfg_ready = 1'b1;
  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != S_IDLE) || !slot_free;
  assign accept    = in_valid && !in_stall;

  iflf_chain u_chain (
    .clk       (clk),
    .ctrl      (chain_ctrl),
    .payload   (payload),
    .head_word (head_word),
    .take_word (take_word)
  );

  // state, counters, result valid flag and limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      in_flight     <= '0;
      max_in_flight <= LIMIT_RESET_VAL;
      out_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      in_flight <= in_flight_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        max_in_flight <= cfg_data;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (emit) begin
      status      <= emit_status;
      item_word   <= emit_word;
      last        <= emit_last;
      entries     <= count_next;
      taken_count <= in_flight_next;
    end
  end

  // request decode and clear sequencing
  always_comb begin
    state_next          = state;
    count_next          = count;
    in_flight_next      = in_flight;
    out_valid_next      = out_valid && out_stall;
    emit                = 1'b0;
    emit_status         = STAT_OK;
    emit_word           = '0;
    emit_last           = 1'b1;
    chain_ctrl.push     = 1'b0;
    chain_ctrl.shift    = 1'b0;
    chain_ctrl.push_idx = count[IDX_W-1:0];
    chain_ctrl.take_idx = in_flight[IDX_W-1:0];

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_PUSH: begin
              emit = 1'b1;
              if (count == DEPTH_COUNT) begin
                emit_status = STAT_FULL;
              end else begin
                chain_ctrl.push = 1'b1;
                count_next      = count + CNT_W'(1);
              end
            end
            OP_TAKE: begin
              emit = 1'b1;
              if (in_flight >= max_in_flight) begin
                emit_status = STAT_LIMIT;
              end else if (in_flight >= count) begin
                emit_status = STAT_EMPTY;
              end else begin
                emit_word      = take_word;
                in_flight_next = in_flight + CNT_W'(1);
              end
            end
            OP_RETIRE: begin
              emit = 1'b1;
              if (count == '0) begin
                emit_status = STAT_EMPTY;
              end else if (in_flight == '0) begin
                emit_status = STAT_NOT_TAKEN;
              end else begin
                chain_ctrl.shift = 1'b1;
                emit_word        = head_word;
                count_next       = count - CNT_W'(1);
                in_flight_next   = in_flight - CNT_W'(1);
              end
            end
            OP_CLEAR_TAKEN: begin
              if (in_flight != '0) begin
                state_next = S_CLEAR_TAKEN;
              end
            end
            OP_CLEAR_ALL: begin
              if (count != '0) begin
                state_next = S_CLEAR_ALL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CLEAR_TAKEN, S_CLEAR_ALL: begin
        if (slot_free) begin
          emit             = 1'b1;
          chain_ctrl.shift = 1'b1;
          emit_word        = head_word;
          count_next       = count - CNT_W'(1);
          in_flight_next   = (in_flight != '0) ? in_flight - CNT_W'(1) : '0;
          emit_last        = (state == S_CLEAR_TAKEN) ? (in_flight_next == '0)
                                                      : (count_next == '0);
          if (emit_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_next = 1'b1;
    end
  end

`ifndef SYNTHESIS
  // taken items are a subset of held items
  assert property (@(posedge clk) disable iff (rst) in_flight <= count)
    else $error("taken count exceeds entries");

  // fill never passes the chain length
  assert property (@(posedge clk) disable iff (rst) count <= DEPTH_COUNT)
    else $error("entry count beyond depth");

  // a taken-clear only runs while taken items remain
  assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR_TAKEN |-> in_flight != '0)
    else $error("taken clear running with nothing taken");

  // a full clear only runs while items remain
  assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR_ALL |-> count != '0)
    else $error("full clear running on empty fifo");

  // an accepted push into a non-full fifo grows it by one
  assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_PUSH && count != DEPTH_COUNT |=> count == $past(count) + CNT_W'(1))
    else $error("push did not add an entry");
`endif

endmodule

[tb/tb_in_flight_limited_fifo_top.sv]
// self-checking testbench for the in-flight limited fifo top level
// depends on iflf_pkg and in_flight_limited_fifo_top; compares every result with a
// cycle-free model of the ring, the in-flight window and the limit register
module tb_in_flight_limited_fifo_top;
  import iflf_pkg::*;

  localparam int RANDOM_ITEMS = 450;
  localparam int QUIET_LIMIT  = 400;
  localparam int SETTLE       = 8;
  localparam int MAX_PRINTS   = 40;

  // spare op codes that the block must ignore
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  // idle styles for both sides
  localparam int IDLE_NONE  = 0;
  localparam int IDLE_LIGHT = 1;
  localparam int IDLE_HEAVY = 2;

  // op mixes for random phases
  localparam int MIX_FILL  = 0;
  localparam int MIX_CHURN = 1;
  localparam int MIX_DRAIN = 2;

  typedef struct {
    logic [2:0]           code;
    logic [WORD_BITS-1:0] word;
    int                   gap;
  } fifo_req_t;

  typedef struct {
    status_t              stat;
    logic [WORD_BITS-1:0] word;
    logic                 fin;
    logic [CNT_W-1:0]     held;
    logic [CNT_W-1:0]     taken;
  } fifo_resp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           op = OP_PUSH;
  logic [WORD_BITS-1:0] payload = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           status;
  logic [WORD_BITS-1:0] item_word;
  logic                 last;
  logic [CNT_W-1:0]     entries;
  logic [CNT_W-1:0]     taken_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CNT_W-1:0]     cfg_data = '0;

  in_flight_limited_fifo_top uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .payload     (payload),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .item_word   (item_word),
    .last        (last),
    .entries     (entries),
    .taken_count (taken_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fifo_req_t  req_queue[$];
  fifo_resp_t expected_resp[$];

  // ring model state
  logic [WORD_BITS-1:0] ring_words [DEPTH];
  int head_idx   = 0;
  int tail_idx   = 0;
  int held_cnt   = 0;
  int taken_cnt  = 0;
  int limit_val  = int'(LIMIT_RESET_VAL);

  int err_count     = 0;
  int req_count     = 0;
  int resp_count    = 0;
  int limit_writes  = 0;
  int random_count  = 0;
  int quiet_cycles  = 0;
  int stall_mode    = IDLE_NONE;
  int status_seen [5];

  logic req_fire  = 1'b0;
  logic resp_fire = 1'b0;

  // ---------------------------------------------------------------------------
  // model of the block

  function automatic void queue_resp(status_t s, logic [WORD_BITS-1:0] w, logic f);
    fifo_resp_t r;
    r.stat  = s;
    r.word  = w;
    r.fin   = f;
    r.held  = CNT_W'(held_cnt);
    r.taken = CNT_W'(taken_cnt);
    expected_resp.push_back(r);
  endfunction

  function automatic logic [WORD_BITS-1:0] drop_oldest();
    logic [WORD_BITS-1:0] w;
    w = ring_words[head_idx];
    head_idx = (head_idx + 1) % DEPTH;
    held_cnt--;
    if (taken_cnt > 0) taken_cnt--;
    return w;
  endfunction

  // expected results of one accepted request
  function automatic void predict_fifo_results(logic [2:0] code, logic [WORD_BITS-1:0] w);
    logic [WORD_BITS-1:0] out_w;
    case (code)
      OP_PUSH: begin
        if (held_cnt >= DEPTH) begin
          queue_resp(STAT_FULL, '0, 1'b1);
        end else begin
          ring_words[tail_idx] = w;
          tail_idx = (tail_idx + 1) % DEPTH;
          held_cnt++;
          queue_resp(STAT_OK, '0, 1'b1);
        end
      end
      OP_TAKE: begin
        // the limit wins over availability
        if (taken_cnt >= limit_val) begin
          queue_resp(STAT_LIMIT, '0, 1'b1);
        end else if (taken_cnt >= held_cnt) begin
          queue_resp(STAT_EMPTY, '0, 1'b1);
        end else begin
          out_w = ring_words[(head_idx + taken_cnt) % DEPTH];
          taken_cnt++;
          queue_resp(STAT_OK, out_w, 1'b1);
        end
      end
      OP_RETIRE: begin
        if (held_cnt == 0) begin
          queue_resp(STAT_EMPTY, '0, 1'b1);
        end else if (taken_cnt == 0) begin
          queue_resp(STAT_NOT_TAKEN, '0, 1'b1);
        end else begin
          out_w = drop_oldest();
          queue_resp(STAT_OK, out_w, 1'b1);
        end
      end
      OP_CLEAR_TAKEN: begin
        while (taken_cnt > 0 && held_cnt > 0) begin
          out_w = drop_oldest();
          queue_resp(STAT_OK, out_w, taken_cnt == 0 || held_cnt == 0);
        end
        taken_cnt = 0;
      end
      OP_CLEAR_ALL: begin
        while (held_cnt > 0) begin
          out_w = drop_oldest();
          queue_resp(STAT_OK, out_w, held_cnt == 0);
        end
        taken_cnt = 0;
      end
      default: begin
        // spare codes: no result, nothing changes
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // mismatch report

  task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] got,
                                 input logic [WORD_BITS-1:0] want);
    if (err_count < MAX_PRINTS)
      $display("mismatch at result %0d: %s got %h expected %h", resp_count, what, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // monitor: prediction, checking and watchdog at the rising edge

  always @(posedge clk) begin
    fifo_resp_t e;
    logic       progress;
    req_fire  <= !rst && in_valid && !in_stall;
    resp_fire <= !rst && out_valid && !out_stall;
    if (!rst) begin
      progress = (in_valid && !in_stall) || (cfg_valid && cfg_ready);
      if (in_valid && !in_stall) begin
        predict_fifo_results(op, payload);
        req_count++;
      end
      if (out_valid && !out_stall) begin
        if (expected_resp.size() == 0) begin
          report_mismatch("result with none pending, status", WORD_BITS'(status), '0);
        end else begin
          progress = 1'b1;
          e = expected_resp.pop_front();
          if (status !== e.stat)
            report_mismatch("status", WORD_BITS'(status), WORD_BITS'(e.stat));
          if (item_word !== e.word)
            report_mismatch("item_word", item_word, e.word);
          if (last !== e.fin)
            report_mismatch("last", WORD_BITS'(last), WORD_BITS'(e.fin));
          if (entries !== e.held)
            report_mismatch("entries", WORD_BITS'(entries), WORD_BITS'(e.held));
          if (taken_count !== e.taken)
            report_mismatch("taken_count", WORD_BITS'(taken_count), WORD_BITS'(e.taken));
          if (int'(e.stat) < 5) status_seen[int'(e.stat)]++;
        end
        resp_count++;
      end
      // watchdog on cycles with no request, no expected result and no limit write
      if (progress)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // idle draws

  function automatic int draw_wait(int mode);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 11) : 0;
      default:    return $urandom_range(0, 11);
    endcase
  endfunction

  // request driver, fed from req_queue, changes at the falling edge
  always @(negedge clk) begin
    static int gap_left = -1;
    fifo_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = -1;
    end else if (!in_valid || req_fire) begin
      if (req_queue.size() != 0 && gap_left < 0) gap_left = req_queue[0].gap;
      if (req_queue.size() != 0 && gap_left == 0) begin
        nxt = req_queue.pop_front();
        in_valid <= 1'b1;
        op       <= nxt.code;
        payload  <= nxt.word;
        gap_left = -1;
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // result stall driver: a fresh wait after every accepted result
  always @(negedge clk) begin
    static int stall_left = 0;
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (resp_fire) stall_left = draw_wait(stall_mode);
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers

  task automatic add_req(input logic [2:0] code, input logic [WORD_BITS-1:0] w,
                         input int mode);
    fifo_req_t r;
    r.code = code;
    r.word = w;
    r.gap  = draw_wait(mode);
    req_queue.push_back(r);
  endtask

  function automatic logic [WORD_BITS-1:0] draw_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_op(int mix);
    int roll;
    int p_push, p_take, p_ret, p_ct, p_ca;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  begin p_push = 55; p_take = 25; p_ret = 12; p_ct = 3; p_ca = 2; end
      MIX_CHURN: begin p_push = 35; p_take = 30; p_ret = 28; p_ct = 3; p_ca = 2; end
      default:   begin p_push = 15; p_take = 40; p_ret = 35; p_ct = 5; p_ca = 2; end
    endcase
    if (roll < p_push) return OP_PUSH;
    roll -= p_push;
    if (roll < p_take) return OP_TAKE;
    roll -= p_take;
    if (roll < p_ret) return OP_RETIRE;
    roll -= p_ret;
    if (roll < p_ct) return OP_CLEAR_TAKEN;
    roll -= p_ct;
    if (roll < p_ca) return OP_CLEAR_ALL;
    return 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
  endfunction

  // well-formed run that fills the ring, saturates the window and empties it
  task automatic add_fill_run(input int mode);
    add_req(OP_CLEAR_ALL, draw_word(), mode);
    repeat (DEPTH + 2) add_req(OP_PUSH, draw_word(), mode);
    repeat (DEPTH + 1) add_req(OP_TAKE, draw_word(), mode);
    repeat (2) add_req(OP_RETIRE, draw_word(), mode);
    repeat (2) add_req(OP_PUSH, draw_word(), mode);
    add_req(OP_CLEAR_TAKEN, draw_word(), mode);
    add_req(OP_CLEAR_ALL, draw_word(), mode);
    random_count += 2 * DEPTH + 10;
  endtask

  task automatic add_random(input int n, input int mix, input int mode);
    logic [2:0] code;
    int added;
    added = 0;
    while (added < n) begin
      code = pick_op(mix);
      add_req(code, draw_word(), mode);
      if (code < OP_SPARE_FIRST) added++;
    end
    random_count += n;
  endtask

  // sender holds off until the block is idle and every result is back
  task automatic wait_idle();
    while (req_queue.size() != 0 || in_valid || expected_resp.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input int v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= CNT_W'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_val = v;
    limit_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // test sequence

  initial begin
    int limit_plan [7] = '{32, 8, 1, 16, 3, 32, 5};
    int phase;
    foreach (ring_words[i]) ring_words[i] = '0;
    foreach (status_seen[i]) status_seen[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty cases, spare codes, word extremes, window basics at reset limit
    add_req(OP_RETIRE, '0, IDLE_LIGHT);
    add_req(OP_TAKE, '0, IDLE_LIGHT);
    add_req(OP_CLEAR_TAKEN, '0, IDLE_LIGHT);
    add_req(OP_CLEAR_ALL, '0, IDLE_LIGHT);
    add_req(OP_SPARE_FIRST, '1, IDLE_LIGHT);
    add_req(OP_SPARE_LAST, '1, IDLE_LIGHT);
    add_req(OP_PUSH, '0, IDLE_LIGHT);
    add_req(OP_PUSH, '1, IDLE_LIGHT);
    add_req(OP_PUSH, draw_word(), IDLE_LIGHT);
    add_req(OP_RETIRE, '0, IDLE_LIGHT);
    add_req(OP_TAKE, '0, IDLE_LIGHT);
    add_req(OP_TAKE, '0, IDLE_LIGHT);
    add_req(OP_RETIRE, '0, IDLE_LIGHT);
    add_req(OP_CLEAR_TAKEN, '0, IDLE_LIGHT);
    add_req(OP_TAKE, '0, IDLE_LIGHT);
    add_req(OP_CLEAR_ALL, '0, IDLE_LIGHT);
    wait_idle();

    // directed: window of one
    write_limit(1);
    add_req(OP_PUSH, draw_word(), IDLE_NONE);
    add_req(OP_PUSH, draw_word(), IDLE_NONE);
    add_req(OP_TAKE, '0, IDLE_NONE);
    add_req(OP_TAKE, '0, IDLE_NONE);
    add_req(OP_RETIRE, '0, IDLE_NONE);
    add_req(OP_CLEAR_ALL, '0, IDLE_NONE);
    wait_idle();

    // directed: zero limit refuses every take, even with nothing held
    write_limit(0);
    add_req(OP_TAKE, '0, IDLE_NONE);
    add_req(OP_PUSH, draw_word(), IDLE_NONE);
    add_req(OP_TAKE, '0, IDLE_NONE);
    add_req(OP_CLEAR_ALL, '0, IDLE_NONE);
    wait_idle();

    // full ring and a saturated window of the widest limit
    write_limit(32);
    stall_mode = IDLE_LIGHT;
    add_fill_run(IDLE_LIGHT);
    wait_idle();

    // random phases across limit settings, op mixes and idle styles
    phase = 0;
    while (random_count < RANDOM_ITEMS) begin
      if (phase < 7) write_limit(limit_plan[phase]);
      else write_limit($urandom_range(1, 32));
      stall_mode = (phase + 1) % 3;
      add_random(40 + $urandom_range(0, 30), phase % 3, phase % 3);
      if (phase == 3) add_fill_run(IDLE_HEAVY);
      wait_idle();
      phase++;
    end

    $display("covered %0d requests and %0d results over %0d limit writes", req_count,
             resp_count, limit_writes);
    $display("status mix: ok %0d, full %0d, empty %0d, limit %0d, oldest not taken %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (err_count == 0 && expected_resp.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/iflf_pkg.sv
sv/iflf_cell.sv
sv/iflf_chain.sv
sv/in_flight_limited_fifo_top.sv
tb/tb_in_flight_limited_fifo_top.sv
